@@ rtl/rhp_pkg.sv @@
// Shared types, constants and the span overlap function for head placement.
`default_nettype none
package rhp_pkg;

  localparam int MAX_HEADS_DEF = 8;

  localparam int COORD_W  = 16;
  localparam int IDX_FW   = 3;   // head index field width
  localparam int CNT_FW   = 4;   // head_count register width
  localparam int OP_W     = 2;
  localparam int AREA_W   = 2 * COORD_W;
  localparam int TOTAL_W  = AREA_W + CNT_FW;  // up to 15 heads summed
  localparam int ENTRY_W  = 4 * COORD_W;

  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIMARY_HEAD  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd3;

  localparam logic [CNT_FW-1:0]  HEAD_COUNT_RST    = 4'd0;
  localparam logic [IDX_FW-1:0]  PRIMARY_HEAD_RST  = 3'd0;
  localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 16'd1024;
  localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 16'd768;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_PLACE = 2'd1,
    OP_POINT = 2'd2,
    OP_NONE  = 2'd3
  } rhp_op_t;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_FULL  = 8'b0000_0010,
    S_SPAN  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_ACC   = 8'b0001_0000,
    S_PSPAN = 8'b0010_0000,
    S_PCHK  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } rhp_state_t;

  // max(0, min(s1+l1, s2+l2) - max(s1, s2)); never exceeds 16 bits
  function automatic logic [COORD_W-1:0] span_ovl(
    input logic signed [COORD_W-1:0] s1,
    input logic        [COORD_W-1:0] l1,
    input logic signed [COORD_W-1:0] s2,
    input logic        [COORD_W-1:0] l2
  );
    logic signed [COORD_W+1:0] a0;
    logic signed [COORD_W+1:0] b0;
    logic signed [COORD_W+1:0] a1;
    logic signed [COORD_W+1:0] b1;
    logic signed [COORD_W+1:0] lo;
    logic signed [COORD_W+1:0] hi;
    logic signed [COORD_W+1:0] diff;
    a0 = {{2{s1[COORD_W-1]}}, s1};
    b0 = {{2{s2[COORD_W-1]}}, s2};
    a1 = a0 + $signed({2'b00, l1});
    b1 = b0 + $signed({2'b00, l2});
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    diff = hi - lo;
    return (hi > lo) ? diff[COORD_W-1:0] : '0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rhp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rhp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic                                    re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/rect_head_placement_core.sv @@
// Head placement: head table, overlap search and point search over one shared unit.
//
// Use: items arrive on the in_ stream; operation travels in in_tuser, the other
// fields in in_tdata. Each transaction gives exactly one result on the out_
// stream. Registers are set through the cfg_ write port; the user must write them
// only while the block is idle, as the block itself does not enforce this. A
// head-table write goes straight to the result. A placement query forms the
// rectangle's area, then its overlap with each counted head (or with the screen
// when at most one head counts); if no head overlaps, a pointer search follows. A
// point query checks the heads in turn. The sequencer steps one table entry at a
// time through the span unit and the single 16x16 multiplier. in_tready is high
// only while the sequencer is idle. A finished result sits in the output register;
// if the receiver stalls, the next transaction is still taken and its result waits
// in the sequencer until the register frees. Reset (rst_n low, synchronous) clears
// the head table to zero by valid bits, restores the register defaults and empties
// the output register; with no clearing pass, items are taken right after reset.
`default_nettype none
module rect_head_placement_core
  import rhp_pkg::*;
#(
  parameter int MAX_HEADS = MAX_HEADS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // head_index[2:0], rect_x[18:3], rect_y[34:19], rect_width[50:35],
  // rect_height[66:51], point_x[82:67], point_y[98:83], zero fill
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  // operation[1:0]
  input  wire logic [OP_W-1:0]       in_tuser,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // chosen_head[2:0], flag_dead[3], flag_partial[4], flag_multiple[5], zero fill
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  localparam int IDX_W = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int CNT_W = $clog2(MAX_HEADS + 1);

  // configuration registers
  logic [CNT_FW-1:0]  head_count_r;
  logic [IDX_FW-1:0]  primary_r;
  logic [COORD_W-1:0] scr_w_r;
  logic [COORD_W-1:0] scr_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_count_r <= HEAD_COUNT_RST;
      primary_r    <= PRIMARY_HEAD_RST;
      scr_w_r      <= SCREEN_WIDTH_RST;
      scr_h_r      <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEAD_COUNT:    head_count_r <= cfg_wdata[CNT_FW-1:0];
        CFG_PRIMARY_HEAD:  primary_r    <= cfg_wdata[IDX_FW-1:0];
        CFG_SCREEN_WIDTH:  scr_w_r      <= cfg_wdata;
        CFG_SCREEN_HEIGHT: scr_h_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic [CNT_W-1:0] n_heads;
  assign n_heads = (int'(head_count_r) < MAX_HEADS) ? CNT_W'(head_count_r)
                                                    : CNT_W'(MAX_HEADS);

  // input field split
  logic [IDX_FW-1:0]         f_idx;
  logic signed [COORD_W-1:0] f_rx, f_ry, f_px, f_py;
  logic [COORD_W-1:0]        f_rw, f_rh;
  rhp_op_t                   f_op;

  assign f_idx = in_tdata[2:0];
  assign f_rx  = in_tdata[18:3];
  assign f_ry  = in_tdata[34:19];
  assign f_rw  = in_tdata[50:35];
  assign f_rh  = in_tdata[66:51];
  assign f_px  = in_tdata[82:67];
  assign f_py  = in_tdata[98:83];
  assign f_op  = rhp_op_t'(in_tuser);

  // sequencer state
  rhp_state_t                state_r, state_nxt;
  logic signed [COORD_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt, px_r, px_nxt, py_r, py_nxt;
  logic [COORD_W-1:0]        rw_r, rw_nxt, rh_r, rh_nxt;
  logic [COORD_W-1:0]        ox_r, ox_nxt, oy_r, oy_nxt;
  logic [AREA_W-1:0]         full_r, full_nxt, area_r, area_nxt, best_r, best_nxt;
  logic [TOTAL_W-1:0]        total_r, total_nxt;
  logic [IDX_W-1:0]          i_r, i_nxt;
  logic [IDX_FW-1:0]         chosen_r, chosen_nxt;
  logic                      scr_r, scr_nxt;
  logic                      found_r, found_nxt;
  logic                      dead_r, dead_nxt, part_r, part_nxt, mult_r, mult_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0]     out_data_r, out_data_nxt;

  // head table
  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_raddr, ram_waddr;
  logic [ENTRY_W-1:0]        ram_wdata, ram_rdata;
  logic [MAX_HEADS-1:0]      valid_r;
  logic                      rd_vld_r;

  rhp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_HEADS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_waddr = IDX_W'(f_idx);
  assign ram_wdata = {f_rh, f_rw, f_ry, f_rx};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (ram_we) begin
        valid_r[ram_waddr] <= 1'b1;
      end
      if (ram_re) begin
        rd_vld_r <= valid_r[ram_raddr];
      end
    end
  end

  // entries never written read as zero
  logic [ENTRY_W-1:0] entry;
  assign entry = rd_vld_r ? ram_rdata : '0;

  // shared span unit operands
  logic                      pmode;
  logic signed [COORD_W-1:0] a_x, a_y, b_x, b_y;
  logic [COORD_W-1:0]        a_w, a_h, b_w, b_h, ovl_x, ovl_y;

  assign pmode = (state_r == S_PSPAN);
  assign a_x   = pmode ? px_r : rx_r;
  assign a_y   = pmode ? py_r : ry_r;
  assign a_w   = pmode ? COORD_W'(1) : rw_r;
  assign a_h   = pmode ? COORD_W'(1) : rh_r;
  assign b_x   = scr_r ? '0 : entry[COORD_W-1:0];
  assign b_y   = scr_r ? '0 : entry[2*COORD_W-1:COORD_W];
  assign b_w   = scr_r ? scr_w_r : entry[3*COORD_W-1:2*COORD_W];
  assign b_h   = scr_r ? scr_h_r : entry[4*COORD_W-1:3*COORD_W];
  assign ovl_x = span_ovl(a_x, a_w, b_x, b_w);
  assign ovl_y = span_ovl(a_y, a_h, b_y, b_h);

  // shared multiplier
  logic [COORD_W-1:0] mul_a, mul_b;
  logic [AREA_W-1:0]  mul_p;
  assign mul_a = (state_r == S_FULL) ? rw_r : ox_r;
  assign mul_b = (state_r == S_FULL) ? rh_r : oy_r;
  assign mul_p = mul_a * mul_b;

  logic [CNT_W-1:0] i_inc;
  logic             last;
  assign i_inc = CNT_W'(i_r) + CNT_W'(1);
  assign last  = (i_inc == n_heads);

  logic [TOTAL_W-1:0] acc_sum;
  logic               better;
  assign acc_sum = total_r + TOTAL_W'(area_r);
  assign better  = (area_r > best_r);

  always_comb begin
    state_nxt     = state_r;
    rx_nxt = rx_r;  ry_nxt = ry_r;  px_nxt = px_r;  py_nxt = py_r;
    rw_nxt = rw_r;  rh_nxt = rh_r;
    ox_nxt = ox_r;  oy_nxt = oy_r;
    full_nxt      = full_r;
    area_nxt      = area_r;
    best_nxt      = best_r;
    total_nxt     = total_r;
    i_nxt         = i_r;
    chosen_nxt    = chosen_r;
    scr_nxt       = scr_r;
    found_nxt     = found_r;
    dead_nxt      = dead_r;
    part_nxt      = part_r;
    mult_nxt      = mult_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          rx_nxt = f_rx;  ry_nxt = f_ry;  px_nxt = f_px;  py_nxt = f_py;
          rw_nxt = f_rw;  rh_nxt = f_rh;
          best_nxt  = '0;
          total_nxt = '0;
          i_nxt     = '0;
          scr_nxt   = 1'b0;
          found_nxt = 1'b0;
          dead_nxt  = 1'b0;
          part_nxt  = 1'b0;
          mult_nxt  = 1'b0;
          chosen_nxt = primary_r;
          case (f_op)
            OP_WRITE: begin
              ram_we     = (int'(f_idx) < MAX_HEADS);
              chosen_nxt = f_idx;
              state_nxt  = S_DONE;
            end
            OP_PLACE: state_nxt = S_FULL;
            OP_POINT: begin
              if (n_heads == '0) begin
                state_nxt = S_DONE;
              end else begin
                ram_re    = 1'b1;
                state_nxt = S_PSPAN;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_FULL: begin
        full_nxt  = mul_p;
        state_nxt = S_SPAN;
        if (n_heads <= CNT_W'(1)) begin
          scr_nxt = 1'b1;
        end else begin
          ram_re = 1'b1;
        end
      end
      S_SPAN: begin
        ox_nxt    = ovl_x;
        oy_nxt    = ovl_y;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        area_nxt  = mul_p;
        state_nxt = S_ACC;
        if (!scr_r && !last) begin
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(i_inc);
        end
      end
      S_ACC: begin
        if (scr_r) begin
          dead_nxt  = (area_r == '0);
          part_nxt  = (area_r != '0) && (area_r != full_r);
          state_nxt = S_DONE;
        end else begin
          total_nxt = acc_sum;
          if (better) begin
            mult_nxt   = found_r;
            best_nxt   = area_r;
            chosen_nxt = IDX_FW'(i_r);
            found_nxt  = 1'b1;
          end
          if (!last) begin
            i_nxt     = IDX_W'(i_inc);
            state_nxt = S_SPAN;
          end else if (!(found_r || better)) begin
            // nothing overlapped: fall back to the head under the pointer
            dead_nxt   = 1'b1;
            chosen_nxt = primary_r;
            i_nxt      = '0;
            ram_re     = 1'b1;
            state_nxt  = S_PSPAN;
          end else begin
            part_nxt  = (acc_sum != TOTAL_W'(full_r));
            state_nxt = S_DONE;
          end
        end
      end
      S_PSPAN: begin
        ox_nxt    = ovl_x;
        oy_nxt    = ovl_y;
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (ox_r != '0 && oy_r != '0) begin
          chosen_nxt = IDX_FW'(i_r);
          state_nxt  = S_DONE;
        end else if (last) begin
          chosen_nxt = primary_r;
          state_nxt  = S_DONE;
        end else begin
          i_nxt     = IDX_W'(i_inc);
          ram_re    = 1'b1;
          ram_raddr = IDX_W'(i_inc);
          state_nxt = S_PSPAN;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, mult_r, part_r, dead_r, chosen_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rx_r <= rx_nxt;  ry_r <= ry_nxt;  px_r <= px_nxt;  py_r <= py_nxt;
    rw_r <= rw_nxt;  rh_r <= rh_nxt;
    ox_r <= ox_nxt;  oy_r <= oy_nxt;
    full_r     <= full_nxt;
    area_r     <= area_nxt;
    best_r     <= best_nxt;
    total_r    <= total_nxt;
    i_r        <= i_nxt;
    chosen_r   <= chosen_nxt;
    scr_r      <= scr_nxt;
    found_r    <= found_nxt;
    dead_r     <= dead_nxt;
    part_r     <= part_nxt;
    mult_r     <= mult_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // a dead rectangle can be neither partial nor improved upon
  a_dead_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[3] && (out_tdata[4] || out_tdata[5])))
    else $error("dead result carries partial or multiple flag");

  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("transaction accepted but sequencer stayed idle");

  // the running sum never falls below the best single overlap
  a_total_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SPAN || state_r == S_MUL || state_r == S_ACC)
      |-> (total_r >= TOTAL_W'(best_r)))
    else $error("overlap total below best area");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for rect_head_placement_core: directed table, then random traffic.
module tb;
  import rhp_pkg::*;

  localparam int HEADS       = MAX_HEADS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 214;

  // in_tdata payload, lowest field last
  typedef struct packed {
    logic signed [15:0] point_y;
    logic signed [15:0] point_x;
    logic        [15:0] rect_height;
    logic        [15:0] rect_width;
    logic signed [15:0] rect_y;
    logic signed [15:0] rect_x;
    logic        [2:0]  head_index;
  } head_req_t;

  // out_tdata[5:0]
  typedef struct packed {
    logic       multiple;
    logic       partial;
    logic       dead;
    logic [2:0] chosen;
  } choice_t;

  typedef struct {
    bit          reconfig;
    logic [3:0]  count;
    logic [2:0]  primary;
    logic [15:0] scr_w;
    logic [15:0] scr_h;
    rhp_op_t     op;
    head_req_t   req;
    bit          typed;
    choice_t     want;
  } step_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [OP_W-1:0]       in_tuser  = OP_NONE;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  rect_head_placement_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // predictor copy of registers and head table
  logic [3:0]  m_count   = HEAD_COUNT_RST;
  logic [2:0]  m_primary = PRIMARY_HEAD_RST;
  logic [15:0] m_scr_w   = SCREEN_WIDTH_RST;
  logic [15:0] m_scr_h   = SCREEN_HEIGHT_RST;
  longint      tbl_left [HEADS] = '{default: 0};
  longint      tbl_top  [HEADS] = '{default: 0};
  longint      tbl_wide [HEADS] = '{default: 0};
  longint      tbl_tall [HEADS] = '{default: 0};

  choice_t pending_choices[$];
  bit      typed_on   = 1'b0;
  choice_t typed_want = '0;
  int      fail_count = 0;
  int      items_taken = 0;
  int      results_seen = 0;
  int      settings_done = 0;
  int      send_idle = 30;
  int      recv_idle = 48;
  bit      hold_pending = 1'b0;
  bit      hold_taken = 1'b0;
  int      hold_left = 0;
  int      quiet = 0;

  function automatic longint span_cover(longint s1, longint l1, longint s2, longint l2);
    longint lo;
    longint hi;
    lo = (s1 > s2) ? s1 : s2;
    hi = (s1 + l1 < s2 + l2) ? s1 + l1 : s2 + l2;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic int counted_heads();
    return (m_count < HEADS) ? int'(m_count) : HEADS;
  endfunction

  // first counted head containing the point, else the primary
  function automatic logic [2:0] head_at(longint px, longint py);
    longint dx;
    longint dy;
    for (int i = 0; i < counted_heads(); i++) begin
      dx = px - tbl_left[i];
      dy = py - tbl_top[i];
      if (dx >= 0 && dx < tbl_wide[i] && dy >= 0 && dy < tbl_tall[i])
        return 3'(i);
    end
    return m_primary;
  endfunction

  function automatic choice_t verdict(int ch, bit d, bit p, bit m);
    choice_t c;
    c.chosen   = 3'(ch);
    c.dead     = d;
    c.partial  = p;
    c.multiple = m;
    return c;
  endfunction

  // works out the result of one transaction and updates the head table
  function automatic choice_t select_head(rhp_op_t op, head_req_t r);
    choice_t c;
    longint  rx;
    longint  ry;
    longint  rw;
    longint  rh;
    longint  full;
    longint  a;
    longint  best;
    longint  total;
    bit      found;
    rx = $signed(r.rect_x);
    ry = $signed(r.rect_y);
    rw = r.rect_width;
    rh = r.rect_height;
    c  = verdict(m_primary, 1'b0, 1'b0, 1'b0);
    case (op)
      OP_WRITE: begin
        tbl_left[r.head_index] = rx;
        tbl_top[r.head_index]  = ry;
        tbl_wide[r.head_index] = rw;
        tbl_tall[r.head_index] = rh;
        c.chosen = r.head_index;
      end
      OP_PLACE: begin
        full = rw * rh;
        if (counted_heads() <= 1) begin
          a = span_cover(rx, rw, 0, m_scr_w) * span_cover(ry, rh, 0, m_scr_h);
          if (a == 0)
            c.dead = 1'b1;
          else if (a != full)
            c.partial = 1'b1;
        end else begin
          best  = 0;
          total = 0;
          found = 1'b0;
          for (int i = 0; i < counted_heads(); i++) begin
            a = span_cover(rx, rw, tbl_left[i], tbl_wide[i]) *
                span_cover(ry, rh, tbl_top[i], tbl_tall[i]);
            total += a;
            if (a > best) begin
              if (found)
                c.multiple = 1'b1;
              best     = a;
              c.chosen = 3'(i);
              found    = 1'b1;
            end
          end
          if (!found) begin
            c.dead   = 1'b1;
            c.chosen = head_at($signed(r.point_x), $signed(r.point_y));
          end else if (total != full) begin
            c.partial = 1'b1;
          end
        end
      end
      OP_POINT: c.chosen = head_at($signed(r.point_x), $signed(r.point_y));
      default: ;
    endcase
    return c;
  endfunction

  // scoreboard: predicts on input transactions, checks output transactions
  always @(posedge clk) begin : scoreboard
    choice_t want;
    choice_t got;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_HEAD_COUNT:    m_count   = cfg_wdata[3:0];
          CFG_PRIMARY_HEAD:  m_primary = cfg_wdata[2:0];
          CFG_SCREEN_WIDTH:  m_scr_w   = cfg_wdata;
          CFG_SCREEN_HEIGHT: m_scr_h   = cfg_wdata;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        want = select_head(rhp_op_t'(in_tuser), head_req_t'(in_tdata[98:0]));
        if (typed_on)
          want = typed_want;
        pending_choices.push_back(want);
        items_taken++;
      end
      if (out_tvalid && out_tready) begin
        got = choice_t'(out_tdata[5:0]);
        if (pending_choices.size() == 0) begin
          $error("unexpected result transaction, data %h", out_tdata);
          fail_count++;
        end else begin
          want = pending_choices.pop_front();
          results_seen++;
          if (got.chosen !== want.chosen) begin
            $error("chosen_head: expected %0d, got %0d", want.chosen, got.chosen);
            fail_count++;
          end
          if (got.dead !== want.dead) begin
            $error("flag_dead: expected %0d, got %0d", want.dead, got.dead);
            fail_count++;
          end
          if (got.partial !== want.partial) begin
            $error("flag_partial: expected %0d, got %0d", want.partial, got.partial);
            fail_count++;
          end
          if (got.multiple !== want.multiple) begin
            $error("flag_multiple: expected %0d, got %0d", want.multiple, got.multiple);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (hold_pending && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic step_t item_row(rhp_op_t op, int idx, int x, int y, int w, int h,
                                     int px, int py, bit typed = 1'b0,
                                     choice_t want = '0);
    step_t s;
    s = '{op: OP_NONE, default: '0};
    s.op                = op;
    s.req.head_index    = 3'(idx);
    s.req.rect_x        = 16'(x);
    s.req.rect_y        = 16'(y);
    s.req.rect_width    = 16'(w);
    s.req.rect_height   = 16'(h);
    s.req.point_x       = 16'(px);
    s.req.point_y       = 16'(py);
    s.typed             = typed;
    s.want              = want;
    return s;
  endfunction

  function automatic step_t cfg_row(int cnt, int prim, int w, int h);
    step_t s;
    s = '{op: OP_NONE, default: '0};
    s.reconfig = 1'b1;
    s.count    = 4'(cnt);
    s.primary  = 3'(prim);
    s.scr_w    = 16'(w);
    s.scr_h    = 16'(h);
    return s;
  endfunction

  task automatic offer(rhp_op_t op, head_req_t req, bit typed, choice_t want);
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid  <= 1'b1;
    in_tuser   <= op;
    in_tdata   <= {5'b0, req};
    typed_on   <= typed;
    typed_want <= want;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // registers change only once every result is back
  task automatic reconfigure(logic [3:0] cnt, logic [2:0] prim, logic [15:0] w,
                             logic [15:0] h);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_HEAD_COUNT;
    cfg_wdata <= {12'b0, cnt};
    @(posedge clk);
    cfg_index <= CFG_PRIMARY_HEAD;
    cfg_wdata <= {13'b0, prim};
    @(posedge clk);
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_done++;
  endtask

  task automatic random_item(output rhp_op_t op, output head_req_t r);
    int roll;
    roll = $urandom_range(99);
    op = (roll < 20) ? OP_WRITE : (roll < 65) ? OP_PLACE : (roll < 93) ? OP_POINT : OP_NONE;
    r.head_index = 3'($urandom_range(7));
    if ($urandom_range(99) < 25) begin
      // full-range noise
      r.rect_x      = 16'($urandom);
      r.rect_y      = 16'($urandom);
      r.rect_width  = 16'($urandom);
      r.rect_height = 16'($urandom);
      r.point_x     = 16'($urandom);
      r.point_y     = 16'($urandom);
    end else begin
      // around the desktop so heads and windows actually meet
      r.rect_x      = 16'($urandom_range(1300) - 150);
      r.rect_y      = 16'($urandom_range(1000) - 150);
      r.rect_width  = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(700));
      r.rect_height = ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(700));
      r.point_x     = 16'($urandom_range(1400) - 200);
      r.point_y     = 16'($urandom_range(1100) - 200);
    end
  endtask

  initial begin : stimulus
    step_t       steps[$];
    step_t       s;
    rhp_op_t     op;
    head_req_t   r;
    logic [3:0]  cnt;
    logic [2:0]  prim;
    logic [15:0] sw;
    logic [15:0] sh;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // defaults after reset: no heads, primary 0, 1024 x 768 screen
    steps.push_back(item_row(OP_PLACE, 0, 0, 0, 1024, 768, 0, 0, 1, verdict(0, 0, 0, 0)));
    steps.push_back(item_row(OP_PLACE, 0, 2000, 100, 10, 10, 0, 0, 1, verdict(0, 1, 0, 0)));
    steps.push_back(item_row(OP_PLACE, 0, -5, 0, 10, 10, 0, 0, 1, verdict(0, 0, 1, 0)));
    steps.push_back(item_row(OP_PLACE, 0, 10, 10, 0, 0, 0, 0, 1, verdict(0, 1, 0, 0)));
    steps.push_back(item_row(OP_POINT, 0, 0, 0, 0, 0, 5, 5, 1, verdict(0, 0, 0, 0)));
    steps.push_back(item_row(OP_NONE, 5, 1, 1, 1, 1, 1, 1, 1, verdict(0, 0, 0, 0)));
    steps.push_back(item_row(OP_WRITE, 7, -32768, -32768, 65535, 65535, 32767, -32768,
                             1, verdict(7, 0, 0, 0)));
    steps.push_back(item_row(OP_WRITE, 0, 32767, 32767, 0, 0, -32768, 32767,
                             1, verdict(0, 0, 0, 0)));
    steps.push_back(cfg_row(3, 5, 65535, 65535));
    steps.push_back(item_row(OP_WRITE, 0, 0, 0, 100, 100, 0, 0, 1, verdict(0, 0, 0, 0)));
    steps.push_back(item_row(OP_WRITE, 1, 100, 0, 100, 100, 0, 0, 1, verdict(1, 0, 0, 0)));
    steps.push_back(item_row(OP_WRITE, 2, 0, 100, 200, 100, 0, 0, 1, verdict(2, 0, 0, 0)));
    // equal overlaps: the earlier head keeps it; a larger later overlap wins
    steps.push_back(item_row(OP_PLACE, 0, 50, 10, 100, 50, 0, 0));
    steps.push_back(item_row(OP_PLACE, 0, 60, 10, 100, 50, 0, 0));
    steps.push_back(item_row(OP_PLACE, 0, 150, 150, 100, 100, 0, 0));
    // dead window: pointer inside a head, then outside all
    steps.push_back(item_row(OP_PLACE, 0, 5000, 5000, 10, 10, 150, 50));
    steps.push_back(item_row(OP_PLACE, 0, 5000, 5000, 10, 10, -1, -1));
    steps.push_back(item_row(OP_POINT, 0, 0, 0, 0, 0, 199, 199));
    steps.push_back(item_row(OP_POINT, 0, 0, 0, 0, 0, 200, 50));
    steps.push_back(item_row(OP_PLACE, 0, -32768, -32768, 65535, 65535, 0, 0));
    steps.push_back(item_row(OP_PLACE, 0, 32767, 32767, 65535, 65535, 32767, -32768));
    // count beyond the table: clamps to eight heads
    steps.push_back(cfg_row(15, 7, 1, 1));
    steps.push_back(item_row(OP_PLACE, 0, 0, 0, 1, 1, 0, 0));
    steps.push_back(item_row(OP_POINT, 0, 0, 0, 0, 0, 32767, 32767));
    steps.push_back(cfg_row(1, 2, 65535, 1));
    steps.push_back(item_row(OP_PLACE, 0, 0, 0, 65535, 1, 0, 0, 1, verdict(2, 0, 0, 0)));
    steps.push_back(item_row(OP_PLACE, 0, -32768, 0, 65535, 1, 0, 0, 1, verdict(2, 0, 1, 0)));

    foreach (steps[i]) begin
      s = steps[i];
      if (s.reconfig)
        reconfigure(s.count, s.primary, s.scr_w, s.scr_h);
      else
        offer(s.op, s.req, s.typed, s.want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin cnt = 4'd2;  prim = 3'd1; sw = 16'd1920;  sh = 16'd1080;  end
        1: begin cnt = 4'd8;  prim = 3'd7; sw = 16'd65535; sh = 16'd65535; end
        2: begin cnt = 4'd1;  prim = 3'd3; sw = 16'd1;     sh = 16'd1;     end
        3: begin cnt = 4'd4;  prim = 3'd0; sw = 16'd800;   sh = 16'd600;   end
        4: begin cnt = 4'd0;  prim = 3'd6; sw = 16'd65535; sh = 16'd1;     end
        default: begin cnt = 4'd15; prim = 3'd2; sw = 16'd1024; sh = 16'd768; end
      endcase
      reconfigure(cnt, prim, sw, sh);
      case (ph / 2)
        0: begin send_idle = 30; recv_idle = 48; end
        1: begin send_idle = 48; recv_idle = 30; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      if (ph == PHASES - 1)
        hold_pending <= 1'b1;
      // lay the heads out as a 4 x 2 grid, then let random traffic disturb it
      for (int h = 0; h < HEADS; h++) begin
        r = '0;
        r.head_index  = 3'(h);
        r.rect_x      = 16'((h % 4) * 300);
        r.rect_y      = 16'((h / 4) * 300);
        r.rect_width  = 16'd300;
        r.rect_height = 16'd300;
        offer(OP_WRITE, r, 1'b0, '0);
      end
      repeat (PHASE_ITEMS) begin
        random_item(op, r);
        offer(op, r, 1'b0, '0);
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("tb: %0d transactions in, %0d results checked, %0d register settings",
             items_taken, results_seen, settings_done);
    $display("tb: random sender/receiver stalls and one %0d-cycle output hold-off covered",
             HOLD_CYCLES);
    if (fail_count == 0 && pending_choices.size() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule
